FILE: rtl/core/mpe_pkg.sv
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types and codes for the msgpack primitive encoder: token kinds,
// format bytes and the descriptor passed from classifier to serialiser.
// ----------------------------------------------------------------------------
package mpe_pkg;

	localparam logic [3:0] ACT_UINT  = 4'd0;
	localparam logic [3:0] ACT_INT   = 4'd1;
	localparam logic [3:0] ACT_FLT64 = 4'd2;
	localparam logic [3:0] ACT_NIL   = 4'd3;
	localparam logic [3:0] ACT_STR   = 4'd4;
	localparam logic [3:0] ACT_BIN   = 4'd5;
	localparam logic [3:0] ACT_ARR   = 4'd6;
	localparam logic [3:0] ACT_MAP   = 4'd7;
	localparam logic [3:0] ACT_RAW   = 4'd8;

	localparam logic [7:0] FMT_UINT8   = 8'hcc;
	localparam logic [7:0] FMT_UINT16  = 8'hcd;
	localparam logic [7:0] FMT_UINT32  = 8'hce;
	localparam logic [7:0] FMT_UINT64  = 8'hcf;
	localparam logic [7:0] FMT_INT8    = 8'hd0;
	localparam logic [7:0] FMT_INT16   = 8'hd1;
	localparam logic [7:0] FMT_INT32   = 8'hd2;
	localparam logic [7:0] FMT_INT64   = 8'hd3;
	localparam logic [7:0] FMT_FLT64   = 8'hcb;
	localparam logic [7:0] FMT_NIL     = 8'hc0;
	localparam logic [7:0] FMT_FIXSTR  = 8'ha0;
	localparam logic [7:0] FMT_STR8    = 8'hd9;
	localparam logic [7:0] FMT_STR16   = 8'hda;
	localparam logic [7:0] FMT_STR32   = 8'hdb;
	localparam logic [7:0] FMT_BIN8    = 8'hc4;
	localparam logic [7:0] FMT_BIN16   = 8'hc5;
	localparam logic [7:0] FMT_BIN32   = 8'hc6;
	localparam logic [7:0] FMT_FIXARR  = 8'h90;
	localparam logic [7:0] FMT_ARR16   = 8'hdc;
	localparam logic [7:0] FMT_ARR32   = 8'hdd;
	localparam logic [7:0] FMT_FIXMAP  = 8'h80;
	localparam logic [7:0] FMT_MAP16   = 8'hde;
	localparam logic [7:0] FMT_MAP32   = 8'hdf;

	// payload byte count after the format byte: 0, 1, 2, 4 or 8
	typedef logic [3:0] nbytes_t;

	typedef struct packed {
		logic [7:0]  head;
		nbytes_t     nbytes;
		logic [63:0] data;
	} desc_t;

	typedef struct packed {
		logic  valid;
		desc_t desc;
	} qhead_t;

endpackage

FILE: rtl/core/mpe_front.sv
// ----------------------------------------------------------------------------
// mpe_front
// Token classifier: picks the msgpack format byte and payload size for each
// accepted token of a known kind and pushes a descriptor into the queue.
// ----------------------------------------------------------------------------
module mpe_front (
	input  logic            item_valid,
	output logic            item_stall,
	input  logic [3:0]      action,
	input  logic [63:0]     value,
	input  logic [31:0]     length,
	input  logic            q_full,
	output logic            push,
	output mpe_pkg::desc_t  desc
);
	import mpe_pkg::*;

	logic known;
	logic neg;
	logic [7:0] head;
	nbytes_t nb;
	logic [63:0] data;
	logic len_le8, len_le16;

	assign neg      = value[63];
	assign len_le8  = (length[31:8] == '0);
	assign len_le16 = (length[31:16] == '0);

	always_comb begin
		known = 1'b1;
		head  = FMT_NIL;
		nb    = 4'd0;
		data  = value;
		case (action)
			ACT_UINT, ACT_INT: begin
				if (action == ACT_INT && neg) begin
					if (&value[63:5]) begin
						head = value[7:0];
					end else if (&value[63:7]) begin
						head = FMT_INT8;
						nb   = 4'd1;
					end else if (&value[63:15]) begin
						head = FMT_INT16;
						nb   = 4'd2;
					end else if (&value[63:31]) begin
						head = FMT_INT32;
						nb   = 4'd4;
					end else begin
						head = FMT_INT64;
						nb   = 4'd8;
					end
				end else begin
					if (value[63:7] == '0) begin
						head = value[7:0];
					end else if (value[63:8] == '0) begin
						head = FMT_UINT8;
						nb   = 4'd1;
					end else if (value[63:16] == '0) begin
						head = FMT_UINT16;
						nb   = 4'd2;
					end else if (value[63:32] == '0) begin
						head = FMT_UINT32;
						nb   = 4'd4;
					end else begin
						head = FMT_UINT64;
						nb   = 4'd8;
					end
				end
			end
			ACT_FLT64: begin
				head = FMT_FLT64;
				nb   = 4'd8;
			end
			ACT_NIL: begin
				head = FMT_NIL;
			end
			ACT_STR: begin
				data = {32'd0, length};
				if (length[31:5] == '0) begin
					head = FMT_FIXSTR | {3'd0, length[4:0]};
				end else if (len_le8) begin
					head = FMT_STR8;
					nb   = 4'd1;
				end else if (len_le16) begin
					head = FMT_STR16;
					nb   = 4'd2;
				end else begin
					head = FMT_STR32;
					nb   = 4'd4;
				end
			end
			ACT_BIN: begin
				data = {32'd0, length};
				if (len_le8) begin
					head = FMT_BIN8;
					nb   = 4'd1;
				end else if (len_le16) begin
					head = FMT_BIN16;
					nb   = 4'd2;
				end else begin
					head = FMT_BIN32;
					nb   = 4'd4;
				end
			end
			ACT_ARR, ACT_MAP: begin
				data = {32'd0, length};
				if (length[31:4] == '0) begin
					head = ((action == ACT_ARR) ? FMT_FIXARR : FMT_FIXMAP)
						| {4'd0, length[3:0]};
				end else if (len_le16) begin
					head = (action == ACT_ARR) ? FMT_ARR16 : FMT_MAP16;
					nb   = 4'd2;
				end else begin
					head = (action == ACT_ARR) ? FMT_ARR32 : FMT_MAP32;
					nb   = 4'd4;
				end
			end
			ACT_RAW: begin
				head = value[7:0];
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// unknown kinds are taken and dropped
	assign item_stall  = q_full;
	assign push        = item_valid && !q_full && known;
	assign desc.head   = head;
	assign desc.nbytes = nb;
	assign desc.data   = data;

endmodule

FILE: rtl/core/mpe_queue.sv
// ----------------------------------------------------------------------------
// mpe_queue
// Two-entry descriptor queue between classifier and serialiser.
// ----------------------------------------------------------------------------
module mpe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mpe_pkg::desc_t  push_desc,
	output logic            full,
	input  logic            pop,
	output mpe_pkg::qhead_t top
);
	import mpe_pkg::*;

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign top.valid = (count_q != 2'd0);
	assign top.desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/mpe_back.sv
// ----------------------------------------------------------------------------
// mpe_back
// Serialiser: emits the format byte then the payload bytes, most significant
// first, one word per cycle through an output register while not stalled.
// ----------------------------------------------------------------------------
module mpe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mpe_pkg::qhead_t top,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            last
);
	import mpe_pkg::*;

	nbytes_t    pos_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       advance;
	logic       fin;
	nbytes_t    idx;
	logic [7:0] cur;

	assign advance = top.valid && (!valid_q || !out_stall);
	assign fin     = (pos_q == top.desc.nbytes);
	assign idx     = top.desc.nbytes - pos_q;
	assign cur     = (pos_q == 4'd0) ? top.desc.head
		: top.desc.data[{idx[2:0], 3'b000} +: 8];
	assign pop     = advance && fin;

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= cur;
			last_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= 4'd0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				pos_q   <= fin ? 4'd0 : pos_q + 4'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;

endmodule

FILE: rtl/core/msgpack_primitive_encoder.sv
// The first word of a token passes through the queue entry, then the output register.
// Throughput: one output word per cycle while a token is queued and out_stall is low;
// the 1 to 9 bytes of each token all pass through the single byte-wide serialiser.
// The two-entry queue lets tokens be taken while earlier ones still drain.
// Reset (arst_n low, asynchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
// msgpack_primitive_encoder
// Encodes each input word of a known kind as one msgpack token in a stream of bytes
// with a final-byte marker; words of an unknown kind are taken and dropped.
// ----------------------------------------------------------------------------
module msgpack_primitive_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  action,
	input  logic [63:0] value,
	input  logic [31:0] length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last
);
	import mpe_pkg::*;

	logic    push;
	logic    q_full;
	logic    pop;
	desc_t   desc;
	qhead_t  qtop;

	mpe_front u_front (
		.item_valid (in_valid),
		.item_stall (in_stall),
		.action     (action),
		.value      (value),
		.length     (length),
		.q_full     (q_full),
		.push       (push),
		.desc       (desc)
	);

	mpe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (desc),
		.full      (q_full),
		.pop       (pop),
		.top       (qtop)
	);

	mpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.top       (qtop),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

FILE: rtl/core/mpe_checker.sv
// ----------------------------------------------------------------------------
// mpe_checker
// Port-level checks for the msgpack primitive encoder, bound to the top level.
// ----------------------------------------------------------------------------
module mpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        last
);
	logic [3:0] run_q;
	logic       seen_q;

	// count words of the token in flight on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 4'd0;
			seen_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				seen_q <= 1'b1;
			end
			if (out_valid && !out_stall) begin
				run_q <= last ? 4'd0 : run_q + 4'd1;
			end
		end
	end

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("stalled output word changed");

	a_max_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |-> run_q < 4'd8)
		else $error("token longer than nine words");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> !out_valid)
		else $error("output word with no token taken");

	a_tail_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last && run_q != 4'd0 |->
		run_q == 4'd1 || run_q == 4'd2 || run_q == 4'd4 || run_q == 4'd8)
		else $error("illegal token length");

endmodule

bind msgpack_primitive_encoder mpe_checker u_mpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.last      (last)
);

FILE: test/tb_msgpack_primitive_encoder.sv
// ----------------------------------------------------------------------------
// tb_msgpack_primitive_encoder
// Self-checking bench for the msgpack primitive encoder. A table of
// directed tokens covers every kind and several width boundaries. Random tokens
// follow. Expected byte streams come from typed table entries or from a
// predictor of the encodings, and are matched word by word against the
// output. Both sides idle at random, and one long output hold fills the
// encoder's queue.
// ----------------------------------------------------------------------------
module tb_msgpack_primitive_encoder;

	import mpe_pkg::*;

	localparam logic [3:0] ACT_UNUSED_MIN = ACT_RAW + 4'd1;
	localparam logic [3:0] ACT_UNUSED_MAX = 4'd15;

	localparam int RAND_TOKENS    = 300;
	localparam int HOLD_CYCLES    = 200;
	localparam int HOLD_AFTER     = 120;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS    = 100;
	localparam int WIDTHS [8]     = '{5, 7, 8, 15, 16, 31, 32, 64};

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} enc_word_t;

	// enc holds the expected bytes right-aligned, first byte highest
	typedef struct packed {
		logic [3:0]  act;
		logic [63:0] val;
		logic [31:0] len;
		logic        typed;
		logic [71:0] enc;
		logic [3:0]  nbytes;
	} token_row_t;

	localparam int DIR_ROWS = 27;
	localparam token_row_t DIR_TAB [DIR_ROWS] = '{
		'{ACT_UINT, 64'h0, 32'h0, 1'b1, 72'h00, 4'd1},
		'{ACT_UINT, 64'h7f, 32'hffff_ffff, 1'b1, 72'h7f, 4'd1},
		'{ACT_UINT, 64'h80, 32'h0, 1'b0, 72'h0, 4'd0},
		'{ACT_UINT, 64'hffff, 32'h0, 1'b0, 72'h0, 4'd0},
		'{ACT_UINT, 64'h1_0000, 32'h0, 1'b0, 72'h0, 4'd0},
		'{ACT_UINT, 64'h1_0000_0000, 32'h0, 1'b0, 72'h0, 4'd0},
		'{ACT_UINT, 64'hffff_ffff_ffff_ffff, 32'h0, 1'b1,
			{FMT_UINT64, 64'hffff_ffff_ffff_ffff}, 4'd9},
		'{ACT_INT, 64'hffff_ffff_ffff_ffff, 32'h0, 1'b1, 72'hff, 4'd1},
		'{ACT_INT, 64'hffff_ffff_ffff_ffe0, 32'h0, 1'b1, 72'he0, 4'd1},
		'{ACT_INT, 64'hffff_ffff_ffff_ffdf, 32'h0, 1'b0, 72'h0, 4'd0},
		'{ACT_INT, 64'hffff_ffff_ffff_ff7f, 32'h0, 1'b0, 72'h0, 4'd0},
		'{ACT_INT, 64'hffff_ffff_ffff_7fff, 32'h0, 1'b0, 72'h0, 4'd0},
		'{ACT_INT, 64'hffff_ffff_7fff_ffff, 32'h0, 1'b0, 72'h0, 4'd0},
		'{ACT_INT, 64'h8000_0000_0000_0000, 32'h0, 1'b1,
			{FMT_INT64, 64'h8000_0000_0000_0000}, 4'd9},
		'{ACT_INT, 64'h7fff_ffff_ffff_ffff, 32'h0, 1'b0, 72'h0, 4'd0},
		'{ACT_FLT64, 64'h0123_4567_89ab_cdef, 32'h0, 1'b1,
			{FMT_FLT64, 64'h0123_4567_89ab_cdef}, 4'd9},
		'{ACT_NIL, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1, {64'h0, FMT_NIL}, 4'd1},
		'{ACT_STR, 64'hffff_ffff_ffff_ffff, 32'd31, 1'b1,
			{64'h0, FMT_FIXSTR | 8'd31}, 4'd1},
		'{ACT_STR, 64'h0, 32'd32, 1'b0, 72'h0, 4'd0},
		'{ACT_STR, 64'h0, 32'hffff_ffff, 1'b1, {32'h0, FMT_STR32, 32'hffff_ffff}, 4'd5},
		'{ACT_BIN, 64'h0, 32'd0, 1'b1, {56'h0, FMT_BIN8, 8'h00}, 4'd2},
		'{ACT_BIN, 64'h0, 32'd256, 1'b0, 72'h0, 4'd0},
		'{ACT_ARR, 64'h0, 32'd16, 1'b0, 72'h0, 4'd0},
		'{ACT_MAP, 64'h0, 32'hffff_ffff, 1'b1, {32'h0, FMT_MAP32, 32'hffff_ffff}, 4'd5},
		'{ACT_RAW, 64'hffff_ffff_ffff_ffa5, 32'hffff_ffff, 1'b1, 72'ha5, 4'd1},
		'{ACT_UNUSED_MIN, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1, 72'h0, 4'd0},
		'{ACT_UNUSED_MAX, 64'h0, 32'h0, 1'b1, 72'h0, 4'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  action = '0;
	logic [63:0] value = '0;
	logic [31:0] length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last;

	// typed expectation riding along with the word on offer
	logic        cur_typed = 1'b0;
	logic [71:0] cur_enc = '0;
	logic [3:0]  cur_nbytes = '0;

	enc_word_t pending_words [$];
	int        fail_count = 0;
	int        tokens_taken = 0;
	int        words_seen = 0;
	int        idle_cycles = 0;
	bit        hold_done = 1'b0;

	msgpack_primitive_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.value     (value),
		.length    (length),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch on output word %0d: %s", words_seen, msg);
	endtask

	// append one expected word at the tail
	function automatic void put_word(input logic [7:0] b, input logic f);
		enc_word_t w;
		w.data = b;
		w.fin  = f;
		pending_words.insert(pending_words.size(), w);
	endfunction

	// head byte, then the low n bytes of data, most significant first
	function automatic void push_bytes(input logic [7:0] head, input logic [63:0] data,
			input int n);
		put_word(head, n == 0);
		for (int i = n - 1; i >= 0; i--)
			put_word(data[8*i +: 8], i == 0);
	endfunction

	function automatic void push_header(input logic [31:0] n, input int fix_max,
			input logic [7:0] fix_base, input bit has8, input logic [7:0] c8,
			input logic [7:0] c16, input logic [7:0] c32);
		if (fix_max >= 0 && n <= fix_max)
			push_bytes(fix_base | n[7:0], 64'h0, 0);
		else if (has8 && n <= 32'hff)
			push_bytes(c8, {32'h0, n}, 1);
		else if (n <= 32'hffff)
			push_bytes(c16, {32'h0, n}, 2);
		else
			push_bytes(c32, {32'h0, n}, 4);
	endfunction

	function automatic void encode_uint(input logic [63:0] v);
		if (v <= 64'h7f)
			push_bytes(v[7:0], 64'h0, 0);
		else if (v <= 64'hff)
			push_bytes(FMT_UINT8, v, 1);
		else if (v <= 64'hffff)
			push_bytes(FMT_UINT16, v, 2);
		else if (v <= 64'hffff_ffff)
			push_bytes(FMT_UINT32, v, 4);
		else
			push_bytes(FMT_UINT64, v, 8);
	endfunction

	function automatic void encode_token(input logic [3:0] act, input logic [63:0] v,
			input logic [31:0] n);
		case (act)
			ACT_UINT: encode_uint(v);
			ACT_INT: begin
				if (!v[63])
					encode_uint(v);
				else if (v >= 64'hffff_ffff_ffff_ffe0)
					push_bytes(v[7:0], 64'h0, 0);
				else if (v >= 64'hffff_ffff_ffff_ff80)
					push_bytes(FMT_INT8, v, 1);
				else if (v >= 64'hffff_ffff_ffff_8000)
					push_bytes(FMT_INT16, v, 2);
				else if (v >= 64'hffff_ffff_8000_0000)
					push_bytes(FMT_INT32, v, 4);
				else
					push_bytes(FMT_INT64, v, 8);
			end
			ACT_FLT64: push_bytes(FMT_FLT64, v, 8);
			ACT_NIL:   push_bytes(FMT_NIL, 64'h0, 0);
			ACT_STR:   push_header(n, 31, FMT_FIXSTR, 1'b1, FMT_STR8, FMT_STR16, FMT_STR32);
			ACT_BIN:   push_header(n, -1, 8'h00, 1'b1, FMT_BIN8, FMT_BIN16, FMT_BIN32);
			ACT_ARR:   push_header(n, 15, FMT_FIXARR, 1'b0, 8'h00, FMT_ARR16, FMT_ARR32);
			ACT_MAP:   push_header(n, 15, FMT_FIXMAP, 1'b0, 8'h00, FMT_MAP16, FMT_MAP32);
			ACT_RAW:   push_bytes(v[7:0], 64'h0, 0);
			default: ;
		endcase
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// mostly values tied to a random width, within it or near its edge, in both signs
	function automatic logic [63:0] rand_value();
		logic [63:0] r;
		logic [63:0] mask;
		int w;
		r = {$urandom, $urandom};
		w = WIDTHS[$urandom_range(0, 7)];
		mask = (64'd1 << w) - 64'd1;
		case ($urandom_range(0, 4))
			0: return r & 64'hff;
			1: return r;
			2: return r & mask;
			3: return r | ~mask;
			default: return ($urandom_range(0, 1) ? mask : ~mask)
				+ 64'($urandom_range(0, 2)) - 64'd1;
		endcase
	endfunction

	function automatic logic [31:0] rand_length();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 40);
			1: return $urandom_range(240, 270);
			2: return $urandom_range(65520, 65550);
			3: return $urandom;
			4: return 32'hffff_ffff - $urandom_range(0, 3);
			default: return $urandom_range(0, 32'h1_ffff);
		endcase
	endfunction

	int burst_left = 0;

	task automatic send_token(input logic [3:0] act, input logic [63:0] v,
			input logic [31:0] n, input logic typed, input logic [71:0] enc,
			input logic [3:0] nbytes);
		int gap;
		if ($urandom_range(0, 39) == 0)
			burst_left = $urandom_range(20, 50);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			gap = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		value      <= v;
		length     <= n;
		cur_typed  <= typed;
		cur_enc    <= enc;
		cur_nbytes <= nbytes;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// stimulus and end of run
	initial begin
		int kept;
		logic [3:0] act;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < DIR_ROWS; i++)
			send_token(DIR_TAB[i].act, DIR_TAB[i].val, DIR_TAB[i].len,
				DIR_TAB[i].typed, DIR_TAB[i].enc, DIR_TAB[i].nbytes);
		kept = 0;
		while (kept < RAND_TOKENS) begin
			if ($urandom_range(0, 9) == 0) begin
				act = 4'($urandom_range(ACT_UNUSED_MIN, ACT_UNUSED_MAX));
			end else begin
				act = 4'($urandom_range(ACT_UINT, ACT_RAW));
				kept++;
			end
			send_token(act, rand_value(), rand_length(), 1'b0, 72'h0, 4'd0);
		end
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// receiver: random stalls, one long hold once HOLD_AFTER tokens are taken
	initial begin
		logic stall_val;
		int dur;
		@(negedge clk);
		forever begin
			if (!hold_done && tokens_taken >= HOLD_AFTER) begin
				stall_val = 1'b1;
				dur = HOLD_CYCLES;
				hold_done = 1'b1;
			end else if ($urandom_range(0, 19) == 0) begin
				stall_val = 1'b0;
				dur = $urandom_range(40, 80);
			end else if ($urandom_range(0, 3) == 0) begin
				stall_val = 1'b1;
				dur = idle_len();
			end else begin
				stall_val = 1'b0;
				dur = $urandom_range(1, 12);
			end
			out_stall <= stall_val;
			repeat (dur) @(negedge clk);
		end
	end

	// predict on each taken token, check each word that leaves
	always @(posedge clk) begin
		enc_word_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tokens_taken++;
				if (cur_typed) begin
					for (int k = 0; k < cur_nbytes; k++)
						put_word(cur_enc[8*(cur_nbytes-1-k) +: 8],
							k == cur_nbytes - 1);
				end else begin
					encode_token(action, value, length);
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word out_byte=%h last=%b",
						out_byte, last));
				end else begin
					want = pending_words.pop_front();
					if (out_byte !== want.data)
						report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.data));
					if (last !== want.fin)
						report_mismatch($sformatf("last %b, want %b", last, want.fin));
				end
				words_seen++;
			end
		end
	end

	// drop out if neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
